FILE: rtl/itoa_pkg.sv
// Shared types, constants and character helpers for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int unsigned ADDRESS_WIDTH = 64;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned HEX_DIGITS = WORD_W / 4;
  localparam int unsigned PTR_DIGITS = (ADDRESS_WIDTH + 3) / 4;
  localparam int unsigned PTR_SHIFT  = VALUE_W - 4 * PTR_DIGITS;

  localparam logic [VALUE_W-1:0] ADDR_MASK = {VALUE_W{1'b1}} >> (VALUE_W - ADDRESS_WIDTH);

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_N       = 8'h6e;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_RPAREN  = 8'h29;

  typedef enum logic [2:0] {
    CMD_SDEC  = 3'd0,
    CMD_UDEC  = 3'd1,
    CMD_HEXL  = 3'd2,
    CMD_HEXU  = 3'd3,
    CMD_PTR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PRE_NONE  = 2'd0,
    PRE_MINUS = 2'd1,
    PRE_HEX   = 2'd2,
    PRE_NIL   = 2'd3
  } pre_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic [4:0] char_index;
    logic       last;
  } out_item_t;

  // One conversion handed to the emitter: prefix, digit nibbles (MS aligned), digit count.
  typedef struct packed {
    logic               start;
    pre_e               kind;
    logic               upper;
    logic [VALUE_W-1:0] digits;
    logic [4:0]         ndig;
  } emit_load_t;

  function automatic logic [2:0] pre_len(input pre_e kind);
    logic [2:0] len;
    begin
      unique case (kind)
        PRE_NONE:  len = 3'd0;
        PRE_MINUS: len = 3'd1;
        PRE_HEX:   len = 3'd2;
        PRE_NIL:   len = 3'd5;
        default:   len = 3'd0;
      endcase
      return len;
    end
  endfunction

  function automatic logic [7:0] pre_char(input pre_e kind, input logic [2:0] idx);
    logic [7:0] ch;
    begin
      ch = CH_ZERO;
      unique case (kind)
        PRE_MINUS: ch = CH_MINUS;
        PRE_HEX:   ch = (idx == 3'd0) ? CH_ZERO : CH_X;
        PRE_NIL: begin
          unique case (idx)
            3'd0:    ch = CH_LPAREN;
            3'd1:    ch = CH_N;
            3'd2:    ch = CH_I;
            3'd3:    ch = CH_L;
            default: ch = CH_RPAREN;
          endcase
        end
        default:   ch = CH_ZERO;
      endcase
      return ch;
    end
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      if (nib < 4'd10) begin
        return CH_ZERO + {4'b0, nib};
      end
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      return base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/itoa_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module itoa_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [itoa_pkg::WORD_W-1:0]   bin_i,
  output logic                          done_o,
  output logic [itoa_pkg::BCD_W-1:0]    bcd_o
);
  import itoa_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [WORD_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [BCD_W-1:0]    bcd_adj;

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                     : bcd_q[4*k +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[WORD_W-1]};
      bin_d = {bin_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: rtl/itoa_emit.sv
// Character emitter: prefix, leading-zero skip, one digit per unstalled cycle into an output register.
module itoa_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itoa_pkg::emit_load_t   load_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output itoa_pkg::out_item_t    out_item_o
);
  import itoa_pkg::*;

  logic               active_q, active_d;
  pre_e               kind_q, kind_d;
  logic               upper_q, upper_d;
  logic [2:0]         pre_idx_q, pre_idx_d;
  logic [VALUE_W-1:0] dig_q, dig_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic               lead_q, lead_d;
  logic [4:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic       can_push, in_pre, skip, push, push_last;
  logic [2:0] plen;
  logic [3:0] top_nib;
  logic [7:0] push_char;

  assign plen     = pre_len(kind_q);
  assign in_pre   = pre_idx_q < plen;
  assign top_nib  = dig_q[VALUE_W-1 -: 4];
  assign can_push = !out_valid_q || !out_stall_i;
  // leading zeros drop out one nibble per cycle; the final digit always goes out
  assign skip     = active_q && !in_pre && lead_q && (top_nib == 4'd0) && (dcnt_q > 5'd1);
  assign push     = active_q && can_push && !skip;

  always_comb begin
    if (in_pre) begin
      push_char = pre_char(kind_q, pre_idx_q);
      push_last = (pre_idx_q == plen - 3'd1) && (dcnt_q == 5'd0);
    end else begin
      push_char = digit_char(top_nib, upper_q);
      push_last = (dcnt_q == 5'd1);
    end
  end

  always_comb begin
    active_d    = active_q;
    kind_d      = kind_q;
    upper_d     = upper_q;
    pre_idx_d   = pre_idx_q;
    dig_d       = dig_q;
    dcnt_d      = dcnt_q;
    lead_d      = lead_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (load_i.start) begin
      active_d  = 1'b1;
      kind_d    = load_i.kind;
      upper_d   = load_i.upper;
      pre_idx_d = '0;
      dig_d     = load_i.digits;
      dcnt_d    = load_i.ndig;
      lead_d    = 1'b1;
      idx_d     = '0;
    end else begin
      if (skip) begin
        dig_d  = {dig_q[VALUE_W-5:0], 4'd0};
        dcnt_d = dcnt_q - 5'd1;
      end
      if (push) begin
        out_valid_d          = 1'b1;
        out_d.character      = push_char;
        out_d.char_index     = idx_q;
        out_d.last           = push_last;
        idx_d                = idx_q + 5'd1;
        if (in_pre) begin
          pre_idx_d = pre_idx_q + 3'd1;
        end else begin
          dig_d  = {dig_q[VALUE_W-5:0], 4'd0};
          dcnt_d = dcnt_q - 5'd1;
          lead_d = 1'b0;
        end
        if (push_last) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      kind_q      <= PRE_NONE;
      pre_idx_q   <= '0;
      dcnt_q      <= '0;
      lead_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      kind_q      <= kind_d;
      pre_idx_q   <= pre_idx_d;
      dcnt_q      <= dcnt_d;
      lead_q      <= lead_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q <= upper_d;
    dig_q   <= dig_d;
    out_q   <= out_d;
  end

  assign busy_o      = active_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter top level: command decode, BCD converter and character emitter.
// Decimal: the BCD converter runs first, then the emitter skips leading zeros and sends the
// optional minus sign and the digits; hex goes straight to the emitter, and a pointer gets a
// 0x prefix or reads "(nil)" when the masked address is zero. A new item is accepted only once
// the emitter has taken the last character of the previous one.
// Output stalls hold the emitter; reset clears all control state and drops any item in flight.
module integer_to_ascii_formatter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itoa_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itoa_pkg::out_item_t  out_item_o
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   neg_q, neg_d;

  logic               accept, is_dec, is_hex, is_ptr;
  logic [WORD_W-1:0]  low32, mag;
  logic [VALUE_W-1:0] addr;
  logic               dab_start, dab_done, emit_busy;
  logic [BCD_W-1:0]   bcd;
  emit_load_t         load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_dec = (in_item_i.command == CMD_SDEC) || (in_item_i.command == CMD_UDEC);
  assign is_hex = (in_item_i.command == CMD_HEXL) || (in_item_i.command == CMD_HEXU);
  assign is_ptr = (in_item_i.command == CMD_PTR);

  assign low32 = in_item_i.value[WORD_W-1:0];
  // 32-bit negate wraps the most negative value onto its own magnitude
  assign mag   = (in_item_i.command == CMD_SDEC && low32[WORD_W-1]) ? (WORD_W'(0) - low32)
                                                                     : low32;
  assign addr  = in_item_i.value & ADDR_MASK;

  assign dab_start = accept && is_dec;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    load    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d = (in_item_i.command == CMD_SDEC) && low32[WORD_W-1];
          if (is_dec) begin
            state_d = ST_CONV;
          end else if (is_hex) begin
            load.start  = 1'b1;
            load.kind   = PRE_NONE;
            load.upper  = (in_item_i.command == CMD_HEXU);
            load.digits = {low32, {(VALUE_W - WORD_W){1'b0}}};
            load.ndig   = 5'(HEX_DIGITS);
            state_d     = ST_EMIT;
          end else if (is_ptr) begin
            load.start = 1'b1;
            load.upper = 1'b0;
            if (addr == '0) begin
              load.kind = PRE_NIL;
              load.ndig = '0;
            end else begin
              load.kind   = PRE_HEX;
              load.digits = addr << PTR_SHIFT;
              load.ndig   = 5'(PTR_DIGITS);
            end
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          load.start  = 1'b1;
          load.kind   = neg_q ? PRE_MINUS : PRE_NONE;
          load.upper  = 1'b0;
          load.digits = {bcd, {(VALUE_W - BCD_W){1'b0}}};
          load.ndig   = 5'(DEC_DIGITS);
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  itoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .bin_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (bcd)
  );

  itoa_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  a_idle_emit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !emit_busy)
    else $error("emitter busy while block idle");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.start |-> !emit_busy)
    else $error("emitter loaded while busy");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.char_index <= 5'd17)
    else $error("character index out of range");

  a_conv_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV && dab_done |=> state_q == ST_EMIT && emit_busy)
    else $error("finished conversion not handed to emitter");
`endif

endmodule

FILE: tb/tb_integer_to_ascii_formatter.sv
// Self-checking testbench for the integer-to-ASCII formatter: directed table, then random items.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
  import itoa_pkg::*;

  localparam int unsigned MAX_CHARS     = 18;
  localparam int unsigned N_DIRECTED    = 25;
  localparam int unsigned N_PRESSURE    = 24;
  localparam int unsigned N_RANDOM      = 424;
  localparam int unsigned GAP_MAX       = 16;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned DEC_RADIX     = 10;
  localparam int unsigned HEX_RADIX     = 16;

  // Commands the block ignores.
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Character run, right-justified: last character in the low byte, zero bytes unused.
  typedef logic [8*MAX_CHARS-1:0] text_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] value;
    logic        has_text;
    text_t       text;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  text_t       text_due_q [$];
  out_item_t   char_due_q [$];
  int unsigned fail_count;
  int unsigned chars_checked;
  int unsigned cmd_count [8];
  logic        hold_off_req;

  // Rows without text are checked against the predictor.
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{CMD_SDEC,  64'h0000_0000_0000_0000, 1'b1, "0"},
    '{CMD_SDEC,  64'h0000_0000_0000_0001, 1'b1, "1"},
    '{CMD_SDEC,  64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"},
    '{CMD_SDEC,  64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
    '{CMD_SDEC,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"},
    '{CMD_SDEC,  64'hFFFF_FFFF_0000_0000, 1'b1, "0"},
    '{CMD_SDEC,  64'h1234_5678_9ABC_DEF0, 1'b0, '0},
    '{CMD_UDEC,  64'h0000_0000_0000_0000, 1'b1, "0"},
    '{CMD_UDEC,  64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
    '{CMD_UDEC,  64'hFFFF_FFFF_3B9A_CA00, 1'b1, "1000000000"},
    '{CMD_UDEC,  64'h5555_5555_AAAA_AAAA, 1'b0, '0},
    '{CMD_HEXL,  64'h0000_0000_0000_0000, 1'b1, "0"},
    '{CMD_HEXL,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "ffffffff"},
    '{CMD_HEXL,  64'h0000_0000_DEAD_BEEF, 1'b1, "deadbeef"},
    '{CMD_HEXU,  64'h0000_0000_0000_0000, 1'b1, "0"},
    '{CMD_HEXU,  64'h0000_0000_FFFF_FFFF, 1'b1, "FFFFFFFF"},
    '{CMD_HEXU,  64'hAAAA_AAAA_00AB_CDEF, 1'b1, "ABCDEF"},
    '{CMD_PTR,   64'h0000_0000_0000_0000, 1'b1, "(nil)"},
    '{CMD_PTR,   64'h0000_0000_0000_0001, 1'b1, "0x1"},
    '{CMD_PTR,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff"},
    '{CMD_PTR,   64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000"},
    '{CMD_PTR,   64'h0000_7FFF_1234_ABCD, 1'b0, '0},
    '{CMD_RSVD5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{CMD_RSVD6, 64'h0000_0000_0000_0000, 1'b1, '0},
    '{CMD_RSVD7, 64'h0000_0000_0000_1234, 1'b1, '0}
  };

  integer_to_ascii_formatter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Shifts the digits of mag onto the end of txt, most significant first.
  function automatic text_t append_digits(input text_t txt, input logic [63:0] mag,
                                          input int unsigned radix, input logic upper);
    logic [7:0] glyphs [$];
    logic [3:0] d;
    do begin
      d = 4'(mag % radix);
      if (d < 4'd10) begin
        glyphs.push_front(CH_ZERO + 8'(d));
      end else begin
        glyphs.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10);
      end
      mag = mag / radix;
    end while (mag != 0);
    foreach (glyphs[k]) begin
      txt = {txt[8*MAX_CHARS-9:0], glyphs[k]};
    end
    return txt;
  endfunction

  function automatic text_t render_item(input in_item_t it);
    text_t       txt;
    logic [31:0] low;
    logic [63:0] addr;
    txt  = '0;
    low  = it.value[31:0];
    addr = it.value & ADDR_MASK;
    case (it.command)
      CMD_SDEC: begin
        if (low[31]) begin
          txt = "-";
          low = -low;  // the most negative value maps onto itself as unsigned
        end
        txt = append_digits(txt, {32'b0, low}, DEC_RADIX, 1'b0);
      end
      CMD_UDEC: txt = append_digits(txt, {32'b0, low}, DEC_RADIX, 1'b0);
      CMD_HEXL: txt = append_digits(txt, {32'b0, low}, HEX_RADIX, 1'b0);
      CMD_HEXU: txt = append_digits(txt, {32'b0, low}, HEX_RADIX, 1'b1);
      CMD_PTR: begin
        if (addr == '0) begin
          txt = "(nil)";
        end else begin
          txt = append_digits("0x", addr, HEX_RADIX, 1'b0);
        end
      end
      default: txt = '0;
    endcase
    return txt;
  endfunction

  function automatic void queue_chars(input text_t txt);
    int        n;
    out_item_t e;
    n = 0;
    for (int k = 0; k < MAX_CHARS; k++) begin
      if (txt[8*k +: 8] != 8'h00) n = k + 1;
    end
    for (int k = n - 1; k >= 0; k--) begin
      e.character  = txt[8*k +: 8];
      e.char_index = 5'(n - 1 - k);
      e.last       = (k == 0);
      char_due_q.push_back(e);
    end
  endfunction

  function automatic void flag_error(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    logic [31:0] low;
    if ($urandom_range(0, 19) == 0) begin
      it.command = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    end else begin
      it.command = 3'($urandom_range(CMD_SDEC, CMD_PTR));
    end
    case ($urandom_range(0, 5))
      0: it.value = {$urandom, $urandom};
      1: it.value = {$urandom, 32'($urandom_range(0, 20))};
      2: begin
        // around the sign boundary and the all-ones word
        low = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        it.value = {$urandom, low + 32'($urandom_range(0, 4)) - 32'd2};
      end
      3: begin
        it.value = 64'd1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1)) it.value = ~it.value;
      end
      4: it.value = {32'b0, $urandom};
      default: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return it;
  endfunction

  task automatic offer(input in_item_t it, input text_t txt, input int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    text_due_q.push_back(txt);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Accepted items turn into expected characters; accepted characters are checked in order.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cmd_count[in_item_i.command]++;
        queue_chars(text_due_q.pop_front());
      end
      if (out_valid_o && !out_stall_i) begin
        chars_checked++;
        if (char_due_q.size() == 0) begin
          flag_error($sformatf("unexpected character 0x%02h index %0d last %0b",
                               out_item_o.character, out_item_o.char_index,
                               out_item_o.last));
        end else begin
          e = char_due_q.pop_front();
          if (out_item_o.character !== e.character ||
              out_item_o.char_index !== e.char_index ||
              out_item_o.last !== e.last) begin
            flag_error($sformatf("expected char 0x%02h idx %0d last %0b, got 0x%02h idx %0d last %0b",
                                 e.character, e.char_index, e.last, out_item_o.character,
                                 out_item_o.char_index, out_item_o.last));
          end
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    logic        quiet_out;
    logic        long_done;
    out_stall_i = 1'b0;
    quiet_out   = 1'b0;
    long_done   = 1'b0;
    taken       = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 32 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      hold = quiet_out ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_off_req && !long_done) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned sent;
    int unsigned rounds;
    logic        quiet_in;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    hold_off_req  = 1'b0;
    fail_count    = 0;
    chars_checked = 0;
    foreach (cmd_count[k]) cmd_count[k] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned k = 0; k < N_DIRECTED; k++) begin
      it.command = dir_rows[k].command;
      it.value   = dir_rows[k].value;
      offer(it, dir_rows[k].has_text ? dir_rows[k].text : render_item(it),
            $urandom_range(0, GAP_MAX));
    end

    // Back-to-back items while the receiver holds off, so the block backs up.
    hold_off_req = 1'b1;
    for (int unsigned k = 0; k < N_PRESSURE; k++) begin
      it = random_item();
      offer(it, render_item(it), 0);
    end

    sent     = 0;
    rounds   = 0;
    quiet_in = 1'b0;
    while (sent < N_RANDOM) begin
      if (rounds % 30 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      rounds++;
      it = random_item();
      offer(it, render_item(it), quiet_in ? 0 : $urandom_range(0, GAP_MAX));
      sent++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (char_due_q.size() != 0 || text_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d sdec, %0d udec, %0d hex-lower, %0d hex-upper, %0d pointer items",
             cmd_count[CMD_SDEC], cmd_count[CMD_UDEC], cmd_count[CMD_HEXL],
             cmd_count[CMD_HEXU], cmd_count[CMD_PTR]);
    $display("plus %0d ignored items; %0d characters checked, %0d errors",
             cmd_count[CMD_RSVD5] + cmd_count[CMD_RSVD6] + cmd_count[CMD_RSVD7],
             chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ERROR: run timed out with %0d characters still due", char_due_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/itoa_pkg.sv
rtl/itoa_dabble.sv
rtl/itoa_emit.sv
rtl/integer_to_ascii_formatter.sv
tb/tb_integer_to_ascii_formatter.sv
